### hdl/lpcc_pkg.sv
// Package with the shared types, codes and defaults of the LED pulse channel controller.
package lpcc_pkg;

  localparam int LPCC_CHANNELS     = 8;
  localparam int LPCC_MAX_CHANNELS = 16;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_SELECT = 3'd1;
  localparam logic [2:0] CMD_BLOCK  = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;

  localparam logic [2:0] ACT_OFF  = 3'd0;
  localparam logic [2:0] ACT_ON   = 3'd1;
  localparam logic [2:0] ACT_IDLE = 3'd2;
  localparam logic [2:0] ACT_POS  = 3'd3;
  localparam logic [2:0] ACT_NEG  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_OPEN = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  localparam logic REG_WRITE_ENABLE = 1'b0;
  localparam logic REG_PULSE_PERIOD = 1'b1;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] channel;
    logic [2:0] action;
    logic       block_on;
  } lpcc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        written;
    logic [15:0] led_levels;
  } lpcc_out_t;

  typedef struct packed {
    logic                         tick;
    logic [LPCC_MAX_CHANNELS-1:0] wr_mask;
    logic [LPCC_MAX_CHANNELS-1:0] blk_mask;
    logic [2:0]                   action;
  } lpcc_chan_ctl_t;

endpackage

### hdl/lpcc_channel.sv
// One LED channel: pending action, hold countdown and drive level.
module lpcc_channel #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lpcc_pkg::lpcc_chan_ctl_t ctl,
  input  logic [7:0]              pulse_period,
  output logic                    level_nxt
);

  logic [2:0] pending_r, pending_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       level_r;

  always_comb begin
    pending_nxt = pending_r;
    hold_nxt    = hold_r;
    level_nxt   = level_r;
    if (ctl.wr_mask[IDX]) begin
      pending_nxt = ctl.action;
    end else if (ctl.blk_mask[IDX]) begin
      pending_nxt = lpcc_pkg::ACT_OFF;
    end else if (ctl.tick) begin
      unique case (pending_r)
        lpcc_pkg::ACT_OFF, lpcc_pkg::ACT_ON: begin
          if (hold_r == 8'd0) begin
            level_nxt   = (pending_r == lpcc_pkg::ACT_ON);
            pending_nxt = lpcc_pkg::ACT_IDLE;
          end else begin
            hold_nxt = hold_r - 8'd1;
          end
        end
        lpcc_pkg::ACT_POS: begin
          hold_nxt    = pulse_period;
          level_nxt   = 1'b1;
          pending_nxt = lpcc_pkg::ACT_OFF;
        end
        lpcc_pkg::ACT_NEG: begin
          hold_nxt    = pulse_period;
          level_nxt   = 1'b0;
          pending_nxt = lpcc_pkg::ACT_ON;
        end
        default: begin
          pending_nxt = pending_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= lpcc_pkg::ACT_IDLE;
      hold_r    <= 8'd0;
      level_r   <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      hold_r    <= hold_nxt;
      level_r   <= level_nxt;
    end
  end

endmodule

### hdl/lpcc_ctrl.sv
// Command decoder with the selected channel, the block mask and the result status.
module lpcc_ctrl #(
  parameter int CHANNELS = lpcc_pkg::LPCC_CHANNELS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  lpcc_pkg::lpcc_in_t       in_item,
  input  logic                     write_enable,
  output lpcc_pkg::lpcc_chan_ctl_t ctl,
  output logic [1:0]               status,
  output logic                     written
);

  logic [7:0]          selected_r, selected_nxt;
  logic [CHANNELS-1:0] blocked_r, blocked_nxt;
  logic [15:0]         blocked_pad;
  logic                sel_in_range;
  logic                chan_in_range;
  logic                wr_ok;

  assign blocked_pad   = 16'(blocked_r);
  assign sel_in_range  = selected_r < 8'(CHANNELS);
  assign chan_in_range = in_item.channel < 8'(CHANNELS);
  assign wr_ok = accept && (in_item.cmd == lpcc_pkg::CMD_WRITE) && (write_enable == 1'b1)
                 && sel_in_range;

  always_comb begin
    ctl.tick     = accept && (in_item.cmd == lpcc_pkg::CMD_TICK);
    ctl.action   = in_item.action;
    ctl.wr_mask  = '0;
    ctl.blk_mask = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      ctl.wr_mask[k]  = wr_ok && (selected_r == 8'(k)) && !blocked_pad[k];
      ctl.blk_mask[k] = accept && (in_item.cmd == lpcc_pkg::CMD_BLOCK)
                        && in_item.block_on && (in_item.channel == 8'(k));
    end
    written = |ctl.wr_mask;
  end

  always_comb begin
    selected_nxt = selected_r;
    blocked_nxt  = blocked_r;
    status       = lpcc_pkg::ST_OK;
    unique case (in_item.cmd)
      lpcc_pkg::CMD_WRITE: begin
        if (write_enable == 1'b0) begin
          status = lpcc_pkg::ST_NOT_OPEN;
        end else if (!sel_in_range) begin
          status = lpcc_pkg::ST_RANGE;
        end
      end
      lpcc_pkg::CMD_SELECT: begin
        if (accept) begin
          selected_nxt = in_item.channel;
        end
      end
      lpcc_pkg::CMD_BLOCK: begin
        if (!chan_in_range) begin
          status = lpcc_pkg::ST_RANGE;
        end else if (accept) begin
          for (int k = 0; k < CHANNELS; k++) begin
            if (in_item.channel == 8'(k)) begin
              blocked_nxt[k] = in_item.block_on;
            end
          end
        end
      end
      lpcc_pkg::CMD_TICK: begin
        status = lpcc_pkg::ST_OK;
      end
      default: begin
        status = lpcc_pkg::ST_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      selected_r <= 8'd0;
      blocked_r  <= '0;
    end else begin
      selected_r <= selected_nxt;
      blocked_r  <= blocked_nxt;
    end
  end

endmodule

### hdl/led_pulse_channel_controller_unit.sv
// Top level of the LED pulse channel controller: configuration, channels and result register.
// The block takes one command transaction per clock cycle while in_ready is high and returns
// exactly one result transaction for it in the next cycle. Every command, including a tick
// that updates all CHANNELS channels in parallel, is decoded and applied when it is accepted,
// and the result (status, written flag and the drive levels after the command) is held in an
// output register; a new command is accepted whenever that register is empty or is being read
// in the same cycle, so the sustained rate is one transaction per cycle while the result side
// keeps up. Configuration writes take effect at the clock edge at which cfg_we is high.
module led_pulse_channel_controller_unit #(
  parameter int CHANNELS = lpcc_pkg::LPCC_CHANNELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpcc_pkg::lpcc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpcc_pkg::lpcc_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);

  logic                     write_enable_r;
  logic [7:0]               pulse_period_r;
  logic                     accept;
  lpcc_pkg::lpcc_chan_ctl_t ctl;
  logic [1:0]               status;
  logic                     written;
  logic [CHANNELS-1:0]      levels_nxt;
  logic                     out_valid_r, out_valid_nxt;
  lpcc_pkg::lpcc_out_t      out_data_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_enable_r <= 1'b0;
      pulse_period_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpcc_pkg::REG_WRITE_ENABLE: write_enable_r <= cfg_wdata[0];
        lpcc_pkg::REG_PULSE_PERIOD: pulse_period_r <= cfg_wdata;
        default:                    pulse_period_r <= pulse_period_r;
      endcase
    end
  end

  lpcc_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_item     (in_data),
    .write_enable(write_enable_r),
    .ctl         (ctl),
    .status      (status),
    .written     (written)
  );

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    lpcc_channel #(
      .IDX(g)
    ) u_chan (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .pulse_period(pulse_period_r),
      .level_nxt   (levels_nxt[g])
    );
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.status     <= status;
      out_data_r.written    <= written;
      out_data_r.led_levels <= 16'(levels_nxt);
    end
  end

endmodule

### hdl/lpcc_checker.sv
// Port-level checker for the LED pulse channel controller, bound to the top level.
module lpcc_checker #(
  parameter int CHANNELS = lpcc_pkg::LPCC_CHANNELS
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input lpcc_pkg::lpcc_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lpcc_pkg::lpcc_out_t out_data
);

  logic [15:0] high_mask;
  assign high_mask = ~16'((17'd1 << CHANNELS) - 17'd1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed or vanished.");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("Accepted transaction produced no result in the next cycle.");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd != lpcc_pkg::CMD_WRITE)
    && (in_data.cmd != lpcc_pkg::CMD_SELECT) && (in_data.cmd != lpcc_pkg::CMD_BLOCK)
    && (in_data.cmd != lpcc_pkg::CMD_TICK)
    |=> out_data.status == lpcc_pkg::ST_UNKNOWN && !out_data.written)
    else $error("Unknown command did not report an unknown status.");

  a_written_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.written |-> out_data.status == lpcc_pkg::ST_OK)
    else $error("Stored write reported an error status.");

  a_unused_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.led_levels & high_mask) == 16'd0)
    else $error("Drive level set on a channel that does not exist.");

endmodule

bind led_pulse_channel_controller_unit lpcc_checker #(
  .CHANNELS(CHANNELS)
) u_lpcc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### sim/led_pulse_channel_controller_unit_test.sv
// Self-checking testbench for the LED pulse channel controller: directed and random traffic.
`timescale 1ns / 1ps

module led_pulse_channel_controller_unit_test;

  localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd4;
  localparam logic [2:0] CMD_LAST_UNKNOWN  = 3'd7;
  localparam logic [2:0] ACT_UNDEFINED     = 3'd7;
  localparam int         IN_BITS           = $bits(lpcc_pkg::lpcc_in_t);
  localparam int         HOLD_CYCLES       = 200;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  lpcc_pkg::lpcc_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lpcc_pkg::lpcc_out_t out_data;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = 1'b0;
  logic [7:0]          cfg_wdata = '0;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  logic        hold_pending  = 1'b0;
  int unsigned error_count   = 0;

  logic [2:0]  shadow_action [lpcc_pkg::LPCC_CHANNELS];
  logic [7:0]  shadow_hold   [lpcc_pkg::LPCC_CHANNELS];
  logic [15:0] shadow_blocked;
  logic [7:0]  shadow_select;
  logic [15:0] shadow_levels;
  logic        shadow_enable;
  logic [7:0]  shadow_period;

  lpcc_pkg::lpcc_out_t led_reports[$];

  led_pulse_channel_controller_unit #(
    .CHANNELS(lpcc_pkg::LPCC_CHANNELS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("[led_pulse_channel_controller_unit] ERROR");
    $finish;
  end

  function automatic void reset_shadow();
    for (int k = 0; k < lpcc_pkg::LPCC_CHANNELS; k++) begin
      shadow_action[k] = lpcc_pkg::ACT_IDLE;
      shadow_hold[k]   = '0;
    end
    shadow_blocked = '0;
    shadow_select  = '0;
    shadow_levels  = '0;
    shadow_enable  = 1'b0;
    shadow_period  = '0;
  endfunction

  // Applies one command to the shadow state and returns the report it produces.
  function automatic lpcc_pkg::lpcc_out_t drive_command(input lpcc_pkg::lpcc_in_t c);
    lpcc_pkg::lpcc_out_t report;
    report = '0;
    report.status = lpcc_pkg::ST_OK;
    case (c.cmd)
      lpcc_pkg::CMD_WRITE: begin
        if (!shadow_enable) begin
          report.status = lpcc_pkg::ST_NOT_OPEN;
        end else if (shadow_select >= lpcc_pkg::LPCC_CHANNELS) begin
          report.status = lpcc_pkg::ST_RANGE;
        end else if (!shadow_blocked[shadow_select]) begin
          shadow_action[shadow_select] = c.action;
          report.written = 1'b1;
        end
      end
      lpcc_pkg::CMD_SELECT: begin
        shadow_select = c.channel;
      end
      lpcc_pkg::CMD_BLOCK: begin
        if (c.channel >= lpcc_pkg::LPCC_CHANNELS) begin
          report.status = lpcc_pkg::ST_RANGE;
        end else if (c.block_on) begin
          shadow_blocked[c.channel] = 1'b1;
          shadow_action[c.channel]  = lpcc_pkg::ACT_OFF;
        end else begin
          shadow_blocked[c.channel] = 1'b0;
        end
      end
      lpcc_pkg::CMD_TICK: begin
        for (int k = 0; k < lpcc_pkg::LPCC_CHANNELS; k++) begin
          case (shadow_action[k])
            lpcc_pkg::ACT_OFF, lpcc_pkg::ACT_ON: begin
              if (shadow_hold[k] == 8'd0) begin
                shadow_levels[k] = (shadow_action[k] == lpcc_pkg::ACT_ON);
                shadow_action[k] = lpcc_pkg::ACT_IDLE;
              end else begin
                shadow_hold[k] = shadow_hold[k] - 8'd1;
              end
            end
            lpcc_pkg::ACT_POS: begin
              shadow_hold[k]   = shadow_period;
              shadow_levels[k] = 1'b1;
              shadow_action[k] = lpcc_pkg::ACT_OFF;
            end
            lpcc_pkg::ACT_NEG: begin
              shadow_hold[k]   = shadow_period;
              shadow_levels[k] = 1'b0;
              shadow_action[k] = lpcc_pkg::ACT_ON;
            end
            default: ;
          endcase
        end
      end
      default: begin
        report.status = lpcc_pkg::ST_UNKNOWN;
      end
    endcase
    report.led_levels = shadow_levels;
    return report;
  endfunction

  function automatic lpcc_pkg::lpcc_in_t compose_command(input logic [2:0] op,
                                                         input logic [7:0] chan,
                                                         input logic [2:0] act,
                                                         input logic blk);
    lpcc_pkg::lpcc_in_t c;
    c.cmd      = op;
    c.channel  = chan;
    c.action   = act;
    c.block_on = blk;
    return c;
  endfunction

  // Mostly well-formed select, write and tick traffic, with blocking and noise mixed in.
  function automatic lpcc_pkg::lpcc_in_t random_command();
    lpcc_pkg::lpcc_in_t c;
    int unsigned        pick;
    c    = lpcc_pkg::lpcc_in_t'(IN_BITS'($urandom));
    pick = $urandom_range(99);
    if (pick < 40) begin
      c.cmd = lpcc_pkg::CMD_TICK;
    end else if (pick < 65) begin
      c.cmd = lpcc_pkg::CMD_WRITE;
      if ($urandom_range(99) < 88) c.action = 3'($urandom_range(lpcc_pkg::ACT_NEG));
    end else if (pick < 80) begin
      c.cmd = lpcc_pkg::CMD_SELECT;
      if ($urandom_range(99) < 85) begin
        c.channel = 8'($urandom_range(lpcc_pkg::LPCC_CHANNELS - 1));
      end
    end else if (pick < 90) begin
      c.cmd = lpcc_pkg::CMD_BLOCK;
      if ($urandom_range(99) < 85) begin
        c.channel = 8'($urandom_range(lpcc_pkg::LPCC_CHANNELS - 1));
      end
    end else begin
      c.cmd = 3'($urandom_range(CMD_LAST_UNKNOWN, CMD_FIRST_UNKNOWN));
    end
    return c;
  endfunction

  task automatic send_command(input lpcc_pkg::lpcc_in_t c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    led_reports.push_back(drive_command(c));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (led_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == lpcc_pkg::REG_WRITE_ENABLE) shadow_enable = value[0];
    else shadow_period = value;
  endtask

  task automatic run_traffic(input int unsigned count);
    repeat (count) send_command(random_command());
    settle();
  endtask

  initial begin : result_drain
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        stall_left   = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : report_check
    lpcc_pkg::lpcc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (led_reports.size() == 0) begin
        $error("unexpected result transaction: status %0d written %0d led_levels %h",
               out_data.status, out_data.written, out_data.led_levels);
        error_count++;
      end else begin
        want = led_reports.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.written !== want.written) begin
          $error("written: expected %0d, got %0d", want.written, out_data.written);
          error_count++;
        end
        if (out_data.led_levels !== want.led_levels) begin
          $error("led_levels: expected %h, got %h", want.led_levels, out_data.led_levels);
          error_count++;
        end
      end
    end
  end

  task automatic test_write_gating();
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, lpcc_pkg::ACT_ON, 1'b0));
    settle();
    write_register(lpcc_pkg::REG_WRITE_ENABLE, 8'd1);
    send_command(compose_command(lpcc_pkg::CMD_SELECT, 8'hFF, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, lpcc_pkg::ACT_ON, 1'b0));
    settle();
  endtask

  task automatic test_channel_actions();
    send_command(compose_command(lpcc_pkg::CMD_SELECT, 8'd7, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, lpcc_pkg::ACT_ON, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_TICK, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, lpcc_pkg::ACT_POS, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_TICK, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_TICK, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, lpcc_pkg::ACT_NEG, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_TICK, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, ACT_UNDEFINED, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_TICK, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    settle();
    write_register(lpcc_pkg::REG_PULSE_PERIOD, 8'd255);
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, lpcc_pkg::ACT_POS, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_TICK, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_TICK, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    settle();
  endtask

  task automatic test_blocking();
    send_command(compose_command(lpcc_pkg::CMD_BLOCK, 8'hFF, lpcc_pkg::ACT_IDLE, 1'b1));
    send_command(compose_command(lpcc_pkg::CMD_SELECT, 8'd3, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, lpcc_pkg::ACT_ON, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_BLOCK, 8'd3, lpcc_pkg::ACT_IDLE, 1'b1));
    send_command(compose_command(lpcc_pkg::CMD_WRITE, 8'h00, lpcc_pkg::ACT_ON, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_BLOCK, 8'd3, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(lpcc_pkg::CMD_TICK, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    settle();
  endtask

  task automatic test_unknown_commands();
    send_command(compose_command(CMD_FIRST_UNKNOWN, 8'h00, lpcc_pkg::ACT_IDLE, 1'b0));
    send_command(compose_command(CMD_LAST_UNKNOWN, 8'hFF, ACT_UNDEFINED, 1'b1));
    settle();
  endtask

  task automatic test_random_traffic();
    write_register(lpcc_pkg::REG_PULSE_PERIOD, 8'd3);
    src_idle_pct  = 28;
    sink_idle_pct = 63;
    run_traffic(560);
    write_register(lpcc_pkg::REG_PULSE_PERIOD, 8'd0);
    src_idle_pct  = 63;
    sink_idle_pct = 28;
    run_traffic(560);
    write_register(lpcc_pkg::REG_PULSE_PERIOD, 8'd1);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_traffic(560);
  endtask

  task automatic test_output_backpressure();
    write_register(lpcc_pkg::REG_PULSE_PERIOD, 8'd255);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_pending  = 1'b1;
    run_traffic(60);
  endtask

  task automatic test_writes_disabled();
    write_register(lpcc_pkg::REG_WRITE_ENABLE, 8'd0);
    src_idle_pct  = 28;
    sink_idle_pct = 28;
    run_traffic(30);
  endtask

  initial begin
    reset_shadow();
    src_idle_pct  = 28;
    sink_idle_pct = 63;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_write_gating();
    test_channel_actions();
    test_blocking();
    test_unknown_commands();
    test_random_traffic();
    test_output_backpressure();
    test_writes_disabled();

    settle();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("[led_pulse_channel_controller_unit] OK");
    end else begin
      $display("[led_pulse_channel_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/lpcc_pkg.sv
hdl/lpcc_channel.sv
hdl/lpcc_ctrl.sv
hdl/led_pulse_channel_controller_unit.sv
hdl/lpcc_checker.sv
sim/led_pulse_channel_controller_unit_test.sv
